FILE: src/bbidp_pkg.sv
// Shared types and constants for the burst-balloons interval optimizer.
// Holds the controller state enum and the command/status structs.
// No dependencies.
`default_nettype none

package bbidp_pkg;

  // Default storage capacity in balloons.
  localparam int MAX_BALLOONS_DEF = 64;

  // Field widths fixed by the interface.
  localparam int VAL_W   = 8;
  localparam int COIN_W  = 32;
  localparam int LR_W    = 2 * VAL_W;
  localparam int PROD_W  = 3 * VAL_W;
  localparam int SUB_W   = COIN_W + 1;
  localparam int CAND_W  = COIN_W + 2;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_EMPTY,
    ST_EDGE_L,
    ST_EDGE_R,
    ST_MUL,
    ST_STEP,
    ST_DRAIN
  } bbidp_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load_en;   // input transfer this cycle
    logic start;     // last item taken: latch set size, reset loader
    logic edge_l;    // read left pad value
    logic edge_r;    // read right pad value, capture left pad
    logic mul;       // form pad product, clear running max
    logic step;      // issue one split position
    logic write;     // store interval best and advance interval
    logic res_load;  // load result register from running max
    logic res_zero;  // load result register with zero (empty set)
  } bbidp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic set_empty;  // no balloon in set including current item
    logic k_at_j;     // split position is at interval end
    logic pipe_busy;  // split candidates still in flight
    logic last_int;   // current interval spans the whole set
    logic res_busy;   // result register holds an untaken result
  } bbidp_status_t;

endpackage

`default_nettype wire

FILE: src/bbidp_ctrl.sv
// Controller state machine for the interval optimizer.
// Sequences loading, per-interval setup, split issue, drain and result.
// Depends on bbidp_pkg.
`default_nettype none

module bbidp_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  input  wire logic                   in_last,
  output logic                        in_tready,
  input  wire bbidp_pkg::bbidp_status_t sts,
  output bbidp_pkg::bbidp_cmd_t       cmd
);

  bbidp_pkg::bbidp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bbidp_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      bbidp_pkg::ST_LOAD: begin
        in_tready   = 1'b1;
        cmd.load_en = in_tvalid;
        if (in_tvalid && in_last) begin
          cmd.start = 1'b1;
          state_nxt = sts.set_empty ? bbidp_pkg::ST_EMPTY : bbidp_pkg::ST_EDGE_L;
        end
      end
      bbidp_pkg::ST_EMPTY: begin
        if (!sts.res_busy) begin
          cmd.res_zero = 1'b1;
          state_nxt    = bbidp_pkg::ST_LOAD;
        end
      end
      bbidp_pkg::ST_EDGE_L: begin
        cmd.edge_l = 1'b1;
        state_nxt  = bbidp_pkg::ST_EDGE_R;
      end
      bbidp_pkg::ST_EDGE_R: begin
        cmd.edge_r = 1'b1;
        state_nxt  = bbidp_pkg::ST_MUL;
      end
      bbidp_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = bbidp_pkg::ST_STEP;
      end
      bbidp_pkg::ST_STEP: begin
        cmd.step = 1'b1;
        if (sts.k_at_j) begin
          state_nxt = bbidp_pkg::ST_DRAIN;
        end
      end
      bbidp_pkg::ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          if (sts.last_int) begin
            // hold until the result register is free
            if (!sts.res_busy) begin
              cmd.write    = 1'b1;
              cmd.res_load = 1'b1;
              state_nxt    = bbidp_pkg::ST_LOAD;
            end
          end else begin
            cmd.write = 1'b1;
            state_nxt = bbidp_pkg::ST_EDGE_L;
          end
        end
      end
      default: begin
        state_nxt = bbidp_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: src/bbidp_dpath.sv
// Datapath for the interval optimizer: value store, interval-best memory,
// interval indices, pad multiplier, split pipeline and result register.
// Depends on bbidp_pkg.
`default_nettype none

module bbidp_dpath #(
  parameter int MAX_BALLOONS = bbidp_pkg::MAX_BALLOONS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire bbidp_pkg::bbidp_cmd_t        cmd,
  input  wire logic [bbidp_pkg::VAL_W-1:0]  in_value,
  input  wire logic                         in_has,
  input  wire logic                         out_tready,
  output bbidp_pkg::bbidp_status_t          sts,
  output logic                              out_tvalid,
  output logic [bbidp_pkg::COIN_W-1:0]      out_max_coins,
  output logic                              out_too_many
);

  localparam int IDX_W      = (MAX_BALLOONS > 1) ? $clog2(MAX_BALLOONS) : 1;
  localparam int CNT_W      = $clog2(MAX_BALLOONS + 1);
  localparam int BEST_DEPTH = 1 << (2 * IDX_W);
  localparam int VAL_W      = bbidp_pkg::VAL_W;
  localparam int COIN_W     = bbidp_pkg::COIN_W;

  // ---------------- loader ----------------
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic             store_ok;
  logic             store_wr;
  logic [CNT_W-1:0] n_cnt;

  logic [VAL_W-1:0] vstore [MAX_BALLOONS];

  assign store_ok = (count_r < CNT_W'(MAX_BALLOONS));
  assign store_wr = cmd.load_en && in_has && store_ok;
  assign n_cnt    = count_r + CNT_W'(store_wr);

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (cmd.start) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end else if (cmd.load_en && in_has) begin
      if (store_ok) begin
        count_nxt = count_r + CNT_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // ---------------- interval indices ----------------
  logic [IDX_W-1:0] n_m1_r;
  logic             tm_r;
  logic [IDX_W-1:0] i_r, j_r, k_r;
  logic             last_int;

  assign last_int = (i_r == '0) && (j_r == n_m1_r);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      n_m1_r <= IDX_W'(n_cnt - CNT_W'(1));
      tm_r   <= ovf_r || (cmd.load_en && in_has && !store_ok);
      i_r    <= '0;
      j_r    <= '0;
    end else if (cmd.write && !last_int) begin
      if (j_r == n_m1_r) begin
        // next length: restart at the left end
        i_r <= '0;
        j_r <= j_r - i_r + IDX_W'(1);
      end else begin
        i_r <= i_r + IDX_W'(1);
        j_r <= j_r + IDX_W'(1);
      end
    end
    if (cmd.mul) begin
      k_r <= i_r;
    end else if (cmd.step) begin
      k_r <= k_r + IDX_W'(1);
    end
  end

  // ---------------- value store ----------------
  logic [IDX_W-1:0] vaddr;
  logic [VAL_W-1:0] v_rd_r;

  always_comb begin
    if (cmd.edge_l) begin
      vaddr = i_r - IDX_W'(1);
    end else if (cmd.edge_r) begin
      vaddr = j_r + IDX_W'(1);
    end else begin
      vaddr = k_r;
    end
  end

  always_ff @(posedge clk) begin
    if (store_wr) begin
      vstore[count_r[IDX_W-1:0]] <= in_value;
    end
    v_rd_r <= vstore[vaddr];
  end

  // ---------------- pad product ----------------
  logic [VAL_W-1:0]              left_r;
  logic [VAL_W-1:0]              right_val;
  logic [bbidp_pkg::LR_W-1:0]    lr_r;

  assign right_val = (j_r == n_m1_r) ? VAL_W'(1) : v_rd_r;

  always_ff @(posedge clk) begin
    if (cmd.edge_r) begin
      left_r <= (i_r == '0) ? VAL_W'(1) : v_rd_r;
    end
    if (cmd.mul) begin
      lr_r <= bbidp_pkg::LR_W'(left_r) * bbidp_pkg::LR_W'(right_val);
    end
  end

  // ---------------- interval-best memory ----------------
  logic [COIN_W-1:0] best_mem [BEST_DEPTH];
  logic [COIN_W-1:0] ba_rd_r, bb_rd_r;
  logic [COIN_W-1:0] rmax_r;

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      best_mem[{i_r, j_r}] <= rmax_r;
    end
    ba_rd_r <= best_mem[{i_r, k_r - IDX_W'(1)}];
    bb_rd_r <= best_mem[{k_r + IDX_W'(1), j_r}];
  end

  // ---------------- split pipeline ----------------
  logic                          p1_valid_r, p2_valid_r;
  logic                          p1_lz_r, p1_rz_r;
  logic [bbidp_pkg::PROD_W-1:0]  prod_r;
  logic [bbidp_pkg::SUB_W-1:0]   sub_r;
  logic [bbidp_pkg::CAND_W-1:0]  cand;
  logic [COIN_W-1:0]             cand_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
      p2_valid_r <= 1'b0;
    end else begin
      p1_valid_r <= cmd.step;
      p2_valid_r <= p1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_lz_r <= (k_r == i_r);
    p1_rz_r <= (k_r == j_r);
    prod_r  <= bbidp_pkg::PROD_W'(lr_r) * bbidp_pkg::PROD_W'(v_rd_r);
    sub_r   <= bbidp_pkg::SUB_W'(p1_lz_r ? '0 : ba_rd_r)
             + bbidp_pkg::SUB_W'(p1_rz_r ? '0 : bb_rd_r);
  end

  assign cand     = bbidp_pkg::CAND_W'(prod_r) + bbidp_pkg::CAND_W'(sub_r);
  assign cand_sat = (cand[bbidp_pkg::CAND_W-1:COIN_W] != '0) ? '1 : cand[COIN_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      rmax_r <= '0;
    end else if (p2_valid_r && (cand_sat > rmax_r)) begin
      rmax_r <= cand_sat;
    end
  end

  // ---------------- result register ----------------
  logic              res_valid_r, res_valid_nxt;
  logic [COIN_W-1:0] res_data_r;
  logic              res_tm_r;

  always_comb begin
    res_valid_nxt = res_valid_r;
    if (cmd.res_load || cmd.res_zero) begin
      res_valid_nxt = 1'b1;
    end else if (out_tready) begin
      res_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_data_r <= rmax_r;
      res_tm_r   <= tm_r;
    end else if (cmd.res_zero) begin
      res_data_r <= '0;
      res_tm_r   <= tm_r;
    end
  end

  assign out_tvalid    = res_valid_r;
  assign out_max_coins = res_data_r;
  assign out_too_many  = res_tm_r;

  // ---------------- status ----------------
  assign sts.set_empty = (count_r == '0) && !in_has;
  assign sts.k_at_j    = (k_r == j_r);
  assign sts.pipe_busy = p1_valid_r || p2_valid_r;
  assign sts.last_int  = last_int;
  assign sts.res_busy  = res_valid_r && !out_tready;

  // ---------------- assertions ----------------
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_BALLOONS))
    else $error("balloon count beyond capacity");

  a_split_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (k_r >= i_r) && (k_r <= j_r))
    else $error("split position outside interval");

  a_write_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write |-> !p1_valid_r && !p2_valid_r)
    else $error("interval best stored with candidates in flight");

  a_res_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.res_load || cmd.res_zero) |-> !(res_valid_r && !out_tready))
    else $error("result register overwritten before transfer");

endmodule

`default_nettype wire

FILE: src/burst_balloons_interval_dp_core.sv
// Burst-balloons interval optimizer, top level.
// Loading takes one input transfer per cycle. After the item marked last, the set's
// intervals are walked by length: for each, the pad values are read and multiplied,
// then one split per cycle goes into the interval-best memory's read ports and the
// pipeline drains; the result is registered. One set at a time; a held result stalls
// the next set. Reset (rst_n low, synchronous) empties the loader.
`default_nettype none

module burst_balloons_interval_dp_core #(
  parameter int MAX_BALLOONS = bbidp_pkg::MAX_BALLOONS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [7:0]                    in_tdata,   // [7:0] balloon_value
  input  wire logic                          in_tuser,   // [0] has_balloon
  input  wire logic                          in_tlast,   // last_item
  // result channel
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [bbidp_pkg::COIN_W-1:0]       out_tdata,  // [31:0] max_coins
  output logic                               out_tuser   // [0] too_many
);

  bbidp_pkg::bbidp_cmd_t    cmd;
  bbidp_pkg::bbidp_status_t sts;

  // Controller: walks intervals by length, one split position per cycle.
  bbidp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_last   (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: stores, indices, pad multiplier, candidate pipeline and the
  // output register that decouples the result transfer from the next set.
  bbidp_dpath #(
    .MAX_BALLOONS (MAX_BALLOONS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_value      (in_tdata[bbidp_pkg::VAL_W-1:0]),
    .in_has        (in_tuser),
    .out_tready    (out_tready),
    .sts           (sts),
    .out_tvalid    (out_tvalid),
    .out_max_coins (out_tdata),
    .out_too_many  (out_tuser)
  );

endmodule

`default_nettype wire
